// File: rtl/tstg_pkg.sv
`timescale 1ns / 1ps
package tstg_pkg;

  localparam int unsigned PHASE_BITS     = 32;
  localparam int unsigned SINE_DEPTH     = 256;
  localparam int unsigned SINE_AW        = 8;
  localparam int unsigned ROM_W          = 15;
  localparam int unsigned AMP_W          = 15;
  localparam int unsigned FREQ_W         = 16;
  localparam int unsigned DUR_W          = 16;
  localparam int unsigned SAMPLE_W       = 16;
  localparam int unsigned CNT_W          = 21;
  localparam int unsigned PROD_W         = 30;
  localparam int unsigned SAMPLES_PER_MS = 24;
  localparam int unsigned TICKS_PER_SEC  = SAMPLES_PER_MS * 1000;

  localparam logic [ROM_W-1:0] Q15_PEAK  = 15'h7fff;
  localparam logic [AMP_W-1:0] AMP_RESET = 15'd3000;
  localparam logic             CMD_TICK  = 1'b0;
  localparam logic             CMD_START = 1'b1;

  // phase step = floor(freq * 2^32 / rate) via reciprocal, exact for 16-bit freq
  localparam int unsigned STEP_SHIFT = 31;
  localparam logic [63:0] STEP_RECIP =
      ((64'd1 << 63) + 64'(TICKS_PER_SEC) - 64'd1) / 64'(TICKS_PER_SEC);

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef logic [ROM_W-1:0] tstg_rom_t [SINE_DEPTH];

  typedef struct packed {
    logic              command;
    logic [FREQ_W-1:0] tone_freq;
    logic [DUR_W-1:0]  tone_duration;
  } tstg_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       amp_enable;
    logic                       busy_res;
  } tstg_out_t;

  // per-tick side information traveling along with the table read
  typedef struct packed {
    logic valid;
    logic tone;
    logic neg;
    logic peak;
    logic amp_enable;
    logic busy;
  } tstg_meta_t;

  typedef struct packed {
    logic               en;
    logic [SINE_AW-1:0] addr;
    logic [ROM_W-1:0]   data;
  } tstg_wr_t;

  // quarter-wave Q15 sine, integer Taylor series, evaluated at elaboration
  function automatic tstg_rom_t build_sine_rom();
    tstg_rom_t   rom;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] v;
    longint      sum;
    for (int k = 0; k < SINE_DEPTH; k++) begin
      x    = (HALF_PI_Q30 * 64'(k)) / 64'(SINE_DEPTH);
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int n = 1; n <= 10; n++) begin
        term = (term * x2) >> 30;
        term = term / 64'((2 * n) * (2 * n + 1));
        if ((n % 2) == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      v = ((64'(sum) * 64'(Q15_PEAK)) + (64'd1 << 29)) >> 30;
      if (v > 64'(Q15_PEAK)) begin
        v = 64'(Q15_PEAK);
      end
      rom[k] = ROM_W'(v);
    end
    return rom;
  endfunction

  localparam tstg_rom_t SINE_ROM = build_sine_rom();

endpackage

// File: rtl/timed_sine_tone_generator_unit.sv
`timescale 1ns / 1ps
// Timed sine tone generator. A start transfer (command 1) sets frequency and duration,
// clears the phase and produces no result; every tick transfer (command 0) produces one
// signed Q15-scaled sample together with amp_enable and busy_res. One transfer is taken
// every clock cycle unless in_stall_o is high; a tick's result passes the sine table
// read, the amplitude multiply and the divide-by-32767 correction, each in its own
// register stage. Right after reset the quarter-wave table RAM is loaded, one entry per
// cycle, so in_stall_o stays high until all 256 entries are written; the amplitude register
// resets to 3000; the user writes it via cfg_wr_en_i only while no tick is in flight (not enforced).
module timed_sine_tone_generator_unit #(
  parameter int unsigned TAIL_SAMPLES = 480
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  tstg_pkg::tstg_in_t         in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output tstg_pkg::tstg_out_t        out_data_o,
  input  logic                       cfg_wr_en_i,
  input  logic [tstg_pkg::AMP_W-1:0] cfg_wr_data_i
);

  import tstg_pkg::*;

  localparam int unsigned TailW = (TAIL_SAMPLES > 1) ? $clog2(TAIL_SAMPLES + 1) : 1;

  tstg_meta_t         iss;
  tstg_wr_t           wr;
  logic               take;
  logic [SINE_AW-1:0] rd_addr;
  logic [ROM_W-1:0]   rd_data;

  tstg_ctrl #(
    .TAIL_SAMPLES (TAIL_SAMPLES),
    .TAIL_W       (TailW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .take_i     (take),
    .in_stall_o (in_stall_o),
    .iss_o      (iss),
    .rd_addr_o  (rd_addr),
    .wr_o       (wr)
  );

  tstg_ram #(
    .WIDTH (ROM_W),
    .DEPTH (SINE_DEPTH)
  ) u_sine_ram (
    .clk_i   (clk_i),
    .we_i    (wr.en),
    .waddr_i (wr.addr),
    .wdata_i (wr.data),
    .re_i    (take),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  tstg_scale u_scale (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .iss_i         (iss),
    .rd_data_i     (rd_data),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .out_stall_i   (out_stall_i),
    .take_o        (take),
    .out_valid_o   (out_valid_o),
    .out_data_o    (out_data_o)
  );

endmodule

// File: rtl/tstg_ram.sv
`timescale 1ns / 1ps
module tstg_ram #(
  parameter int unsigned WIDTH = 15,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/tstg_ctrl.sv
`timescale 1ns / 1ps
module tstg_ctrl #(
  parameter int unsigned TAIL_SAMPLES = 480,
  parameter int unsigned TAIL_W       = 9
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  tstg_pkg::tstg_in_t             in_data_i,
  input  logic                           take_i,
  output logic                           in_stall_o,
  output tstg_pkg::tstg_meta_t           iss_o,
  output logic [tstg_pkg::SINE_AW-1:0]   rd_addr_o,
  output tstg_pkg::tstg_wr_t             wr_o
);

  import tstg_pkg::*;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_TONE,
    MODE_TAIL,
    MODE_SILENCE
  } mode_e;

  localparam mode_e             AFTER_TONE = (TAIL_SAMPLES > 0) ? MODE_TAIL : MODE_IDLE;
  localparam logic [TAIL_W-1:0] TAIL_LOAD  = TAIL_W'(TAIL_SAMPLES);

  mode_e                 mode_q, mode_d;
  logic [PHASE_BITS-1:0] phase_acc_q, phase_acc_d;
  logic [PHASE_BITS-1:0] phase_step_q, phase_step_d;
  logic [CNT_W-1:0]      samples_left_q, samples_left_d;
  logic [TAIL_W-1:0]     tail_left_q, tail_left_d;
  logic                  fill_q, fill_d;
  logic [SINE_AW-1:0]    fill_cnt_q, fill_cnt_d;

  logic                  accept;
  logic                  start;
  logic                  tick;
  logic [79:0]           step_prod;
  logic [PHASE_BITS-1:0] step_calc;
  logic [CNT_W:0]        cnt_full;
  logic [CNT_W-1:0]      cnt;
  logic [CNT_W-1:0]      sl_dec;
  logic [TAIL_W-1:0]     tl_dec;
  logic [SINE_AW+1:0]    idx;
  logic [1:0]            quad;
  logic [SINE_AW-1:0]    off;

  assign in_stall_o = fill_q || !take_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign start      = accept && (in_data_i.command == CMD_START);
  assign tick       = accept && (in_data_i.command == CMD_TICK);

  assign step_prod = {64'b0, in_data_i.tone_freq} * {16'b0, STEP_RECIP};
  assign step_calc = step_prod[STEP_SHIFT +: PHASE_BITS];

  assign cnt_full = (CNT_W + 1)'(in_data_i.tone_duration) * (CNT_W + 1)'(SAMPLES_PER_MS);
  assign cnt      = cnt_full[CNT_W] ? {CNT_W{1'b1}} : cnt_full[CNT_W-1:0];

  assign sl_dec = samples_left_q - CNT_W'(samples_left_q != '0);
  assign tl_dec = tail_left_q - TAIL_W'(tail_left_q != '0);

  // quadrant and offset from the top phase bits, odd quadrants mirror the table
  assign idx       = phase_acc_q[PHASE_BITS-1 -: SINE_AW + 2];
  assign quad      = idx[SINE_AW+1:SINE_AW];
  assign off       = idx[SINE_AW-1:0];
  assign rd_addr_o = quad[0] ? ({SINE_AW{1'b0}} - off) : off;

  always_comb begin
    iss_o.valid      = tick;
    iss_o.tone       = (mode_q == MODE_TONE);
    iss_o.neg        = quad[1];
    iss_o.peak       = quad[0] && (off == '0);
    iss_o.amp_enable = (mode_q == MODE_TONE) || (mode_q == MODE_TAIL);
    iss_o.busy       = (mode_q != MODE_IDLE);
  end

  always_comb begin
    wr_o.en   = fill_q;
    wr_o.addr = fill_cnt_q;
    wr_o.data = SINE_ROM[fill_cnt_q];
  end

  always_comb begin
    mode_d         = mode_q;
    phase_acc_d    = phase_acc_q;
    phase_step_d   = phase_step_q;
    samples_left_d = samples_left_q;
    tail_left_d    = tail_left_q;
    fill_d         = fill_q;
    fill_cnt_d     = fill_cnt_q;

    // table load after reset
    if (fill_q) begin
      fill_cnt_d = fill_cnt_q + 1'b1;
      if (fill_cnt_q == SINE_AW'(SINE_DEPTH - 1)) begin
        fill_d = 1'b0;
      end
    end

    if (start) begin
      phase_acc_d    = '0;
      samples_left_d = cnt;
      tail_left_d    = '0;
      if (in_data_i.tone_freq == '0) begin
        phase_step_d = '0;
        mode_d       = (cnt != '0) ? MODE_SILENCE : MODE_IDLE;
      end else begin
        phase_step_d = step_calc;
        if (cnt != '0) begin
          mode_d = MODE_TONE;
        end else begin
          tail_left_d = TAIL_LOAD;
          mode_d      = AFTER_TONE;
        end
      end
    end else if (tick) begin
      case (mode_q)
        MODE_TONE: begin
          phase_acc_d    = phase_acc_q + phase_step_q;
          samples_left_d = sl_dec;
          if (sl_dec == '0) begin
            tail_left_d = TAIL_LOAD;
            mode_d      = AFTER_TONE;
          end
        end
        MODE_TAIL: begin
          tail_left_d = tl_dec;
          if (tl_dec == '0) begin
            mode_d = MODE_IDLE;
          end
        end
        MODE_SILENCE: begin
          samples_left_d = sl_dec;
          if (sl_dec == '0) begin
            mode_d = MODE_IDLE;
          end
        end
        default: begin
          mode_d = MODE_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q         <= MODE_IDLE;
      phase_acc_q    <= '0;
      phase_step_q   <= '0;
      samples_left_q <= '0;
      tail_left_q    <= '0;
      fill_q         <= 1'b1;
      fill_cnt_q     <= '0;
    end else begin
      mode_q         <= mode_d;
      phase_acc_q    <= phase_acc_d;
      phase_step_q   <= phase_step_d;
      samples_left_q <= samples_left_d;
      tail_left_q    <= tail_left_d;
      fill_q         <= fill_d;
      fill_cnt_q     <= fill_cnt_d;
    end
  end

  a_no_tick_during_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q |-> !iss_o.valid)
    else $error("tick issued while sine table is loading");

  a_tone_has_samples: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_TONE) || (mode_q == MODE_SILENCE) |-> samples_left_q != '0)
    else $error("tone or silence running with no samples left");

  a_silence_no_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == MODE_SILENCE |-> phase_step_q == '0)
    else $error("silence period with nonzero phase step");

endmodule

// File: rtl/tstg_scale.sv
`timescale 1ns / 1ps
module tstg_scale (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tstg_pkg::tstg_meta_t          iss_i,
  input  logic [tstg_pkg::ROM_W-1:0]    rd_data_i,
  input  logic                          cfg_wr_en_i,
  input  logic [tstg_pkg::AMP_W-1:0]    cfg_wr_data_i,
  input  logic                          out_stall_i,
  output logic                          take_o,
  output logic                          out_valid_o,
  output tstg_pkg::tstg_out_t           out_data_o
);

  import tstg_pkg::*;

  logic [AMP_W-1:0]    amp_q;
  logic                v1_q, v2_q, v3_q;
  tstg_meta_t          m1_q, m2_q;
  logic [PROD_W-1:0]   p2_q;
  tstg_out_t           out_q;

  logic                take2, take3;
  logic [ROM_W-1:0]    tab;
  logic [PROD_W-1:0]   prod;
  logic [PROD_W:0]     est_sum;
  logic [SAMPLE_W-1:0] q0;
  logic [31:0]         rem;
  logic [SAMPLE_W-1:0] mag;
  tstg_out_t           out_d;

  // a stage loads when it is empty or its content moves on
  assign take3  = !v3_q || !out_stall_i;
  assign take2  = !v2_q || take3;
  assign take_o = !v1_q || take2;

  assign tab  = m1_q.peak ? Q15_PEAK : rd_data_i;
  assign prod = {15'b0, tab} * {15'b0, amp_q};

  // floor(p / 32767): estimate from below, then one correction step
  assign est_sum = {1'b0, p2_q} + (PROD_W + 1)'(p2_q[PROD_W-1:15]);
  assign q0      = est_sum[PROD_W:15];
  assign rem     = {2'b0, p2_q} + 32'(q0) - 32'({q0, 15'b0});
  assign mag     = (rem >= 32'(Q15_PEAK)) ? q0 + 1'b1 : q0;

  always_comb begin
    out_d.amp_enable = m2_q.amp_enable;
    out_d.busy_res   = m2_q.busy;
    if (!m2_q.tone) begin
      out_d.sample = '0;
    end else if (m2_q.neg) begin
      out_d.sample = $signed(SAMPLE_W'(-mag));
    end else begin
      out_d.sample = $signed(mag);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amp_q <= AMP_RESET;
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
    end else begin
      if (cfg_wr_en_i) begin
        amp_q <= cfg_wr_data_i;
      end
      if (take_o) begin
        v1_q <= iss_i.valid;
      end
      if (take2) begin
        v2_q <= v1_q;
      end
      if (take3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      m1_q <= iss_i;
    end
    if (take2) begin
      m2_q <= m1_q;
      p2_q <= prod;
    end
    if (take3) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = v3_q;
  assign out_data_o  = out_q;

  a_sample_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> out_q.sample != 16'sh8000)
    else $error("sample magnitude beyond Q15 peak");

  a_silent_when_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && !out_q.amp_enable |-> out_q.sample == '0)
    else $error("nonzero sample with amplifier off");

  a_stall_keeps_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && v3_q && out_stall_i |=> v2_q && v3_q)
    else $error("result lost while output stalled");

endmodule

// File: bench/tb_timed_sine_tone_generator_unit.sv
`timescale 1ns / 1ps
module tb_timed_sine_tone_generator_unit;
  import tstg_pkg::*;

  localparam int unsigned TABLE_DEPTH  = 256;
  localparam int unsigned SAMPLES_MS   = 24;
  localparam int unsigned TONE_RATE    = 24000;
  localparam int unsigned TAIL_LEN     = 480;
  localparam int unsigned Q15_MAX      = 32767;
  localparam int unsigned AMP_AT_RESET = 3000;
  localparam logic [63:0] HALF_PI_FIX  = 64'd1686629713;
  localparam int unsigned RESULT_LAG   = 12;
  localparam int unsigned HOLD_CYCLES  = 120;
  localparam int unsigned HOLD_AFTER   = 200;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  typedef enum logic [1:0] {GEN_IDLE, GEN_TONE, GEN_TAIL, GEN_SILENCE} gen_mode_e;

  class tone_tracker;
    logic [14:0]      quarter_sine [TABLE_DEPTH];
    logic [AMP_W-1:0] amplitude;
    logic [31:0]      phase;
    logic [31:0]      step;
    logic [CNT_W-1:0] tone_left;
    logic [8:0]       tail_left;
    gen_mode_e        mode;
    tstg_out_t        due_samples[$];
    int unsigned      errors;
    int unsigned      n_starts;
    int unsigned      n_tone;
    int unsigned      n_tail;
    int unsigned      n_silent;
    int unsigned      n_idle;

    function new();
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] v;
      longint      acc;
      // quarter-wave table from a fixed-point taylor series of sin
      for (int k = 0; k < TABLE_DEPTH; k++) begin
        x    = (HALF_PI_FIX * 64'(k)) / 64'(TABLE_DEPTH);
        x2   = (x * x) >> 30;
        term = x;
        acc  = longint'(x);
        for (int n = 1; n <= 10; n++) begin
          term = (term * x2) >> 30;
          term = term / 64'(4 * n * n + 2 * n);
          if (n % 2 == 1) begin
            acc -= longint'(term);
          end else begin
            acc += longint'(term);
          end
        end
        if (acc < 0) begin
          acc = 0;
        end
        v = (64'(acc) * 64'(Q15_MAX) + (64'd1 << 29)) >> 30;
        quarter_sine[k] = (v > 64'(Q15_MAX)) ? 15'(Q15_MAX) : v[14:0];
      end
      amplitude = AMP_W'(AMP_AT_RESET);
      phase     = '0;
      step      = '0;
      tone_left = '0;
      tail_left = '0;
      mode      = GEN_IDLE;
      errors    = 0;
      n_starts  = 0;
      n_tone    = 0;
      n_tail    = 0;
      n_silent  = 0;
      n_idle    = 0;
    endfunction

    function logic signed [15:0] sine_at_phase();
      logic [1:0]  quad;
      logic [7:0]  j;
      int unsigned t;
      int unsigned mag;
      quad = phase[31:30];
      j    = phase[29:22];
      // odd quadrants run the table backwards, offset zero is the peak
      if (quad[0]) begin
        t = (j == 0) ? Q15_MAX : quarter_sine[TABLE_DEPTH - j];
      end else begin
        t = quarter_sine[j];
      end
      mag = (t * amplitude) / Q15_MAX;
      return quad[1] ? -16'(mag) : 16'(mag);
    endfunction

    function void accept_command(tstg_in_t it);
      tstg_out_t   r;
      int unsigned cnt;
      if (it.command == CMD_START) begin
        cnt       = it.tone_duration * SAMPLES_MS;
        n_starts++;
        phase     = '0;
        tone_left = CNT_W'(cnt);
        tail_left = '0;
        if (it.tone_freq == '0) begin
          step = '0;
          mode = (cnt > 0) ? GEN_SILENCE : GEN_IDLE;
        end else begin
          step = 32'((64'(it.tone_freq) << 32) / 64'(TONE_RATE));
          if (cnt > 0) begin
            mode = GEN_TONE;
          end else begin
            tail_left = 9'(TAIL_LEN);
            mode      = GEN_TAIL;
          end
        end
        return;
      end
      r = '0;
      case (mode)
        GEN_TONE: begin
          r.sample     = sine_at_phase();
          r.amp_enable = 1'b1;
          r.busy_res   = 1'b1;
          phase        = phase + step;
          if (tone_left > 0) tone_left--;
          if (tone_left == 0) begin
            tail_left = 9'(TAIL_LEN);
            mode      = GEN_TAIL;
          end
          n_tone++;
        end
        GEN_TAIL: begin
          r.amp_enable = 1'b1;
          r.busy_res   = 1'b1;
          if (tail_left > 0) tail_left--;
          if (tail_left == 0) mode = GEN_IDLE;
          n_tail++;
        end
        GEN_SILENCE: begin
          r.busy_res = 1'b1;
          if (tone_left > 0) tone_left--;
          if (tone_left == 0) mode = GEN_IDLE;
          n_silent++;
        end
        default: begin
          mode = GEN_IDLE;
          n_idle++;
        end
      endcase
      due_samples.push_back(r);
    endfunction

    function void check_sample(tstg_out_t got);
      tstg_out_t want;
      if (due_samples.size() == 0) begin
        $error("unexpected result transfer: sample %0d amp_enable %0b busy_res %0b",
               got.sample, got.amp_enable, got.busy_res);
        errors++;
        return;
      end
      want = due_samples.pop_front();
      if (got.sample !== want.sample) begin
        $error("sample: expected %0d, actual %0d", want.sample, got.sample);
        errors++;
      end
      if (got.amp_enable !== want.amp_enable) begin
        $error("amp_enable: expected %0b, actual %0b", want.amp_enable, got.amp_enable);
        errors++;
      end
      if (got.busy_res !== want.busy_res) begin
        $error("busy_res: expected %0b, actual %0b", want.busy_res, got.busy_res);
        errors++;
      end
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  tstg_in_t         in_data_i;
  logic             out_valid_o;
  logic             out_stall_i;
  tstg_out_t        out_data_o;
  logic             cfg_wr_en_i;
  logic [AMP_W-1:0] cfg_wr_data_i;

  tone_tracker board;
  int unsigned src_idle_pct;
  int unsigned sink_stall_pct;
  int unsigned n_results = 0;
  int unsigned cycle_cnt = 0;

  timed_sine_tone_generator_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_data_i     (in_data_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_data_o    (out_data_o),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      board.check_sample(out_data_o);
      n_results++;
    end
  end

  // receiver: random stalls plus one long hold to back the block up
  initial begin
    int unsigned hold_left;
    bit          hold_done;
    hold_left   = 0;
    hold_done   = 1'b0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else if (!hold_done && n_results >= HOLD_AFTER) begin
        hold_done   = 1'b1;
        hold_left   = HOLD_CYCLES - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < sink_stall_pct);
      end
    end
  end

  function automatic tstg_in_t tick_item();
    tstg_in_t it;
    it.command       = CMD_TICK;
    it.tone_freq     = 16'($urandom());
    it.tone_duration = 16'($urandom());
    return it;
  endfunction

  // entered and left at a falling edge
  task automatic send_item(tstg_in_t it);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    board.accept_command(it);
    @(negedge clk_i);
  endtask

  task automatic send_ticks(int unsigned n);
    repeat (n) send_item(tick_item());
  endtask

  task automatic send_start(logic [15:0] freq, logic [15:0] dur);
    tstg_in_t it;
    it.command       = CMD_START;
    it.tone_freq     = freq;
    it.tone_duration = dur;
    send_item(it);
  endtask

  task automatic go_quiet();
    in_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk_i); while (board.due_samples.size() != 0);
    // a trailing start transfer may still be in flight
    repeat (RESULT_LAG) @(posedge clk_i);
  endtask

  task automatic write_amplitude(logic [AMP_W-1:0] value);
    @(negedge clk_i);
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= value;
    @(negedge clk_i);
    cfg_wr_en_i   <= 1'b0;
    board.amplitude = value;
  endtask

  task automatic run_directed();
    send_ticks(1);                  // idle tick
    send_start(16'd1000, 16'd1);
    send_ticks(4);
    send_start(16'hffff, 16'd0);    // aliased step, straight to the tail
    send_ticks(2);
    send_start(16'd0, 16'd0);       // nothing to do, stays idle
    send_ticks(1);
    send_start(16'd0, 16'd1);       // silent period, run out to idle
    send_ticks(SAMPLES_MS + 2);
    send_start(16'd1000, 16'd1);    // full tone, whole tail, then idle
    send_ticks(SAMPLES_MS + TAIL_LEN + 2);
    send_start(16'd23999, 16'hffff);
    send_ticks(3);
    send_start(16'd6000, 16'd1);    // quarter-turn steps hit the peak entry
    send_ticks(5);
    send_start(16'd12000, 16'd2);
    send_ticks(2);
  endtask

  task automatic run_random(int unsigned budget);
    int unsigned sent;
    int unsigned run;
    logic [15:0] freq;
    logic [15:0] dur;
    int unsigned sel;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(99) < 6) begin
        send_ticks(1);
        sent++;
        continue;
      end
      case ($urandom_range(9))
        0:       freq = 16'd0;
        1:       freq = 16'hffff;
        2:       freq = 16'(6000 * $urandom_range(1, 4));
        3:       freq = 16'($urandom_range(1, 100));
        default: freq = 16'($urandom());
      endcase
      sel = $urandom_range(9);
      if (sel == 0) begin
        dur = 16'd0;
      end else if (sel == 1) begin
        dur = 16'($urandom());
      end else begin
        dur = 16'($urandom_range(1, 3));
      end
      // now and then run a short tone all the way through its tail to idle
      if (dur <= 3 && $urandom_range(9) == 0) begin
        run = dur * SAMPLES_MS + ((freq != 0) ? TAIL_LEN : 0) + $urandom_range(1, 16);
      end else begin
        run = $urandom_range(1, 60);
      end
      // keep the item count within the budget
      if (run >= budget - sent) begin
        run = budget - sent - 1;
      end
      send_start(freq, dur);
      send_ticks(run);
      sent += run + 1;
    end
  endtask

  initial begin
    logic [AMP_W-1:0] amp_rand;
    board         = new();
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    cfg_wr_en_i   = 1'b0;
    cfg_wr_data_i = '0;
    src_idle_pct   = 19;
    sink_stall_pct = 45;
    amp_rand = AMP_W'($urandom_range(1, 32766));
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    run_directed();
    run_random(150);

    go_quiet();
    wait_drained();
    src_idle_pct   = 45;
    sink_stall_pct = 19;
    write_amplitude(AMP_W'(Q15_MAX));
    run_random(150);

    go_quiet();
    wait_drained();
    write_amplitude('0);
    run_random(50);

    go_quiet();
    wait_drained();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    write_amplitude(amp_rand);
    run_random(150);

    go_quiet();
    wait_drained();
    $display("run covered %0d start transfers and ticks in tone %0d, tail %0d,",
             board.n_starts, board.n_tone, board.n_tail);
    $display("silence %0d, idle %0d; amplitude 3000, 32767, 0 and %0d; hold of %0d cycles",
             board.n_silent, board.n_idle, amp_rand, HOLD_CYCLES);
    if (board.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
